### hdl/signed_int_to_decimal_ascii_unit_assert.svh
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit assertion macros
// checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH

// same-cycle implication
`define SIDA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SIDA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/sida_pkg.sv
// ----------------------------------------------------------------------------
// sida_pkg
// shared types, constants and helpers of the decimal ascii converter
// ----------------------------------------------------------------------------
package sida_pkg;

    localparam int DEFAULT_VALUE_BITS = 32;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_SIGN,
        ST_DIGIT
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic drop;
        logic sel_sign;
    } dp_cmd_t;

    typedef struct packed {
        logic bits_done;
        logic top_zero;
        logic one_digit;
        logic neg;
    } dp_status_t;

    // decimal digits that cover a magnitude of the given bit width
    // 1233 / 4096 is just below log10(2)
    function automatic int digit_count(input int bits);
        return ((bits * 1233) >>> 12) + 1;
    endfunction

endpackage

### hdl/sida_ctrl.sv
// ----------------------------------------------------------------------------
// sida_ctrl
// sequencer: load, shift-add-3 conversion, leading zero skip, character output
// ----------------------------------------------------------------------------
module sida_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 value_valid,
    output logic                 value_ready,
    output logic                 ascii_valid,
    input  logic                 ascii_ready,
    output logic                 last,
    input  sida_pkg::dp_status_t status,
    output sida_pkg::dp_cmd_t    cmd
);
    import sida_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (value_valid)
                begin
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                if (status.bits_done)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (!(status.top_zero && !status.one_digit))
                begin
                    state_next = status.neg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN:
            begin
                if (ascii_ready)
                begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (ascii_ready && status.one_digit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        value_ready  = 1'b0;
        ascii_valid  = 1'b0;
        last         = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                value_ready = 1'b1;
                cmd.load    = value_valid;
            end
            ST_CONVERT:
            begin
                cmd.step = 1'b1;
            end
            ST_SKIP:
            begin
                // drop zero digits but always keep one
                cmd.drop = status.top_zero && !status.one_digit;
            end
            ST_SIGN:
            begin
                ascii_valid  = 1'b1;
                cmd.sel_sign = 1'b1;
            end
            ST_DIGIT:
            begin
                ascii_valid = 1'b1;
                last        = status.one_digit;
                cmd.drop    = ascii_ready;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### hdl/sida_dpath.sv
// ----------------------------------------------------------------------------
// sida_dpath
// magnitude and bcd shift register, one double-dabble bit per step
// ----------------------------------------------------------------------------
module sida_dpath
#(
    parameter int VALUE_BITS = sida_pkg::DEFAULT_VALUE_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic signed [VALUE_BITS-1:0] value,
    input  sida_pkg::dp_cmd_t            cmd,
    output sida_pkg::dp_status_t         status,
    output logic [7:0]                   ascii_char
);
    import sida_pkg::*;

    localparam int NDIG   = digit_count(VALUE_BITS);
    localparam int BCD_W  = 4 * NDIG;
    localparam int CNT_W  = $clog2(VALUE_BITS);
    localparam int DCNT_W = $clog2(NDIG + 1);

    logic [VALUE_BITS-1:0] mag_reg;
    logic [VALUE_BITS-1:0] mag_next;
    logic [BCD_W-1:0]      bcd_reg;
    logic [BCD_W-1:0]      bcd_next;
    logic                  neg_reg;
    logic                  neg_next;
    logic [CNT_W-1:0]      bit_cnt_reg;
    logic [CNT_W-1:0]      bit_cnt_next;
    logic [DCNT_W-1:0]     dig_left_reg;
    logic [DCNT_W-1:0]     dig_left_next;

    logic [BCD_W-1:0]      bcd_adj;
    logic [3:0]            top_digit;

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        logic [3:0] d;
        d = '0;
        for (int i = 0; i < NDIG; i++)
        begin
            d = bcd_reg[4*i +: 4];
            bcd_adj[4*i +: 4] = (d >= 4'd5) ? (d + 4'd3) : d;
        end
    end

    always_comb
    begin
        mag_next      = mag_reg;
        bcd_next      = bcd_reg;
        neg_next      = neg_reg;
        bit_cnt_next  = bit_cnt_reg;
        dig_left_next = dig_left_reg;
        if (cmd.load)
        begin
            neg_next      = value[VALUE_BITS-1];
            // unsigned negate keeps the most negative value exact
            mag_next      = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
            bcd_next      = '0;
            bit_cnt_next  = '0;
            dig_left_next = DCNT_W'(NDIG);
        end
        else if (cmd.step)
        begin
            {bcd_next, mag_next} = {bcd_adj, mag_reg} << 1;
            bit_cnt_next         = bit_cnt_reg + 1'b1;
        end
        else if (cmd.drop)
        begin
            bcd_next      = bcd_reg << 4;
            dig_left_next = dig_left_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg  <= '0;
            dig_left_reg <= '0;
        end
        else
        begin
            bit_cnt_reg  <= bit_cnt_next;
            dig_left_reg <= dig_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
    end

    assign top_digit        = bcd_reg[BCD_W-1 -: 4];
    assign status.bits_done = (bit_cnt_reg == CNT_W'(VALUE_BITS - 1));
    assign status.top_zero  = (top_digit == 4'd0);
    assign status.one_digit = (dig_left_reg == DCNT_W'(1));
    assign status.neg       = neg_reg;
    assign ascii_char       = cmd.sel_sign ? CHAR_MINUS : (CHAR_ZERO + {4'd0, top_digit});

endmodule

### hdl/signed_int_to_decimal_ascii_unit.sv
// a load, VALUE_BITS shift-add-3 steps, then skip steps that drop leading zero digits,
// then one character per cycle when the sink is ready
// one number at a time: a new value is taken only after the last beat is delivered
// rst_n clears the sequencer to idle and the counters, asynchronously
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// signed integer in, decimal ascii characters out, most significant first
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_unit_assert.svh"

module signed_int_to_decimal_ascii_unit
#(
    parameter int VALUE_BITS = sida_pkg::DEFAULT_VALUE_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         value_valid,
    output logic                         value_ready,
    input  logic signed [VALUE_BITS-1:0] value,
    output logic                         ascii_valid,
    input  logic                         ascii_ready,
    output logic [7:0]                   ascii_char,
    output logic                         last
);
    import sida_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    sida_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_valid (value_valid),
        .value_ready (value_ready),
        .ascii_valid (ascii_valid),
        .ascii_ready (ascii_ready),
        .last        (last),
        .status      (status),
        .cmd         (cmd)
    );

    sida_dpath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (value),
        .cmd        (cmd),
        .status     (status),
        .ascii_char (ascii_char)
    );

    `SIDA_ASSERT_NOW(a_no_overlap, value_ready, !ascii_valid, "input taken while output busy")
    `SIDA_ASSERT_NEXT(a_take_busy, value_valid && value_ready, !value_ready, "second value taken")
    `SIDA_ASSERT_NEXT(a_last_idle, ascii_valid && ascii_ready && last, value_ready, "no idle after last")
    `SIDA_ASSERT_NOW(a_char_set, ascii_valid, (ascii_char == CHAR_MINUS) || ((ascii_char >= CHAR_ZERO) && (ascii_char <= CHAR_NINE)), "bad character")

endmodule
